// ===== rtl/twm_pkg.sv =====
// Shared types and constants for the toy word machine executor.
// Holds the channel payloads, the controller/datapath command and status
// structs, status, mode, state and opcode enums. No dependencies.
package twm_pkg;

    // Fixed widths of the item fields
    localparam int ADDR_W = 7;
    localparam int WORD_W = 32;
    localparam int CHAR_W = 8;

    // Item commands
    localparam logic [1:0] CMD_LOAD = 2'd0;
    localparam logic [1:0] CMD_STEP = 2'd1;
    localparam logic [1:0] CMD_DATA = 2'd2;

    // Characters
    localparam logic [7:0] CH_USCORE = 8'h5F;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_G      = 8'h47;
    localparam logic [7:0] CH_D      = 8'h44;
    localparam logic [7:0] CH_P      = 8'h50;
    localparam logic [7:0] CH_H      = 8'h48;
    localparam logic [7:0] CH_L      = 8'h4C;
    localparam logic [7:0] CH_R      = 8'h52;
    localparam logic [7:0] CH_S      = 8'h53;
    localparam logic [7:0] CH_C      = 8'h43;
    localparam logic [7:0] CH_B      = 8'h42;
    localparam logic [7:0] CH_T      = 8'h54;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_AWAIT  = 3'd1,
        ST_HALT   = 3'd2,
        ST_ADDR   = 3'd3,
        ST_REJECT = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        MODE_RUN   = 2'd0,
        MODE_AWAIT = 2'd1,
        MODE_HALT  = 2'd2,
        MODE_FAULT = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_GD,
        OP_PD,
        OP_H,
        OP_LR,
        OP_SR,
        OP_CR,
        OP_BT
    } op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_DECODE,
        S_LR_WAIT,
        S_CR_WAIT,
        S_PD_NL,
        S_PD_READ,
        S_PD_BYTES,
        S_H_NL1,
        S_H_NL2,
        S_FINISH
    } ctrl_state_t;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [ADDR_W-1:0] load_address;
        logic [WORD_W-1:0] load_word;
        logic [CHAR_W-1:0] data_char;
    } req_item_t;

    typedef struct packed {
        logic [CHAR_W-1:0] out_char;
        logic              char_valid;
        logic              last;
        logic [2:0]        status;
        logic [ADDR_W-1:0] counter_value;
    } rsp_item_t;

    // Controller to datapath
    typedef struct packed {
        logic    take_item;
        logic    mem_load;
        logic    fetch;
        logic    read_oper;
        logic    do_lr;
        logic    do_cr;
        logic    do_sr;
        logic    do_bt;
        logic    start_gd;
        logic    data_store;
        logic    pd_start;
        logic    pd_read;
        logic    pd_byte;
        logic    push_nl;
        logic    finish;
        logic    set_status;
        status_t status;
        logic    set_mode;
        mode_t   mode;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [1:0] cmd;
        logic       load_ok;
        mode_t      mode;
        logic       counter_ok;
        op_t        op;
        logic       oper_ok;
        logic       pd_ok;
        logic       toggle;
        logic       started;
        logic       is_space;
        logic       is_newline;
        logic       fill_ok;
        logic       push_blocked;
        logic       out_free;
        logic       pd_skip;
        logic       pd_done;
    } dp_status_t;

endpackage

// ===== rtl/twm_req_if.sv =====
// Request channel: valid/ready handshake carrying one input item.
// Depends on twm_pkg for the payload type.
interface twm_req_if;
    logic              valid;
    logic              ready;
    twm_pkg::req_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/twm_rsp_if.sv =====
// Response channel: valid/ready handshake carrying one result item.
// Depends on twm_pkg for the payload type.
interface twm_rsp_if;
    logic              valid;
    logic              ready;
    twm_pkg::rsp_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/toy_word_machine_executor_unit.sv =====
// Toy word machine executor: 32-bit word memory of ASCII-coded instructions
// with LR/SR/CR/BT/GD/PD/H. Input items arrive on req, result items leave on rsp.
// Uses twm_pkg, twm_req_if, twm_rsp_if, twm_ctrl and twm_datapath.
//
// Each request item (cmd 0 load, 1 step, 2 GD data character) yields one or
// more result items on rsp; the final one carries last, and every result of
// an item carries the same status and counter_value. An item with no
// character gives a single result with char_valid low.
// Items are handled one at a time: req.ready is high only while the
// controller is idle. LR and CR make one extra read of the single memory
// read port. PD reads one word at a time and walks one byte a cycle while
// rsp does not stall; every PD after the first opens with a newline. The
// last result is registered and may still wait on rsp while the next item
// is accepted.
// A stalled rsp holds the byte walk; one character waits in a hold stage and
// one in the output register. Reset clears the machine registers and mode;
// memory contents stay undefined until loaded, so no clearing pass runs.
module toy_word_machine_executor_unit #(
    parameter int MEM_WORDS   = 100,
    parameter int BLOCK_WORDS = 10
) (
    input  logic      clk,
    input  logic      rst_n,
    twm_req_if.sink   req,
    twm_rsp_if.source rsp
);

    twm_pkg::dp_cmd_t    dp_cmd;
    twm_pkg::dp_status_t dp_sts;

    twm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .sts       (dp_sts),
        .cmd       (dp_cmd)
    );

    twm_datapath #(
        .MEM_WORDS   (MEM_WORDS),
        .BLOCK_WORDS (BLOCK_WORDS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_payload (req.payload),
        .cmd         (dp_cmd),
        .sts         (dp_sts),
        .rsp_ready   (rsp.ready),
        .rsp_valid   (rsp.valid),
        .rsp_payload (rsp.payload)
    );

endmodule

// ===== rtl/twm_datapath.sv =====
// Datapath: word memory, machine registers, instruction decode, PD byte
// walker, one-character hold stage and the result output register.
// Depends on twm_pkg; driven by twm_ctrl through dp_cmd_t.
module twm_datapath #(
    parameter int MEM_WORDS   = 100,
    parameter int BLOCK_WORDS = 10
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  twm_pkg::req_item_t     req_payload,
    input  twm_pkg::dp_cmd_t       cmd,
    output twm_pkg::dp_status_t    sts,
    input  logic                   rsp_ready,
    output logic                   rsp_valid,
    output twm_pkg::rsp_item_t     rsp_payload
);

    localparam int AW     = $clog2(MEM_WORDS);
    localparam int FILL_W = $clog2(4 * MEM_WORDS + 1);
    localparam int BW     = $clog2(BLOCK_WORDS + 1);
    localparam int AXW    = twm_pkg::ADDR_W;

    logic [twm_pkg::WORD_W-1:0] word_mem [MEM_WORDS];

    twm_pkg::req_item_t         item_reg;
    logic [31:0]                gen_reg;
    logic [31:0]                mem_q_reg;
    logic                       toggle_reg;
    logic                       started_reg;
    logic [AXW-1:0]             counter_reg;
    logic [AXW-1:0]             pd_ptr_reg;
    logic [BW-1:0]              pd_left_reg;
    logic [1:0]                 pd_idx_reg;
    logic [FILL_W-1:0]          fill_reg;
    twm_pkg::mode_t             mode_reg;
    twm_pkg::status_t           status_reg;
    logic                       pend_valid_reg;
    logic [7:0]                 pend_char_reg;
    logic                       out_valid_reg;
    twm_pkg::rsp_item_t         out_item_reg;

    logic [7:0]     op0, op1, hi, lo;
    logic           digits_ok;
    logic [AXW-1:0] oper;
    logic           oper_ok;
    logic           pd_ok;
    twm_pkg::op_t   op;
    logic [7:0]     pd_char;
    logic           pd_skip;
    logic           pd_done;
    logic           out_free;

    logic           mem_we;
    logic [AW-1:0]  mem_waddr;
    logic [31:0]    mem_wdata;
    logic [3:0]     mem_be;
    logic           mem_re;
    logic [AW-1:0]  mem_raddr;

    logic           push_en;
    logic [7:0]     push_char;
    logic           emit;
    twm_pkg::rsp_item_t emit_item;

    // Decode the word held at the memory read register
    always_comb
    begin
        op0 = mem_q_reg[31:24];
        op1 = mem_q_reg[23:16];
        hi  = mem_q_reg[15:8];
        lo  = mem_q_reg[7:0];
        digits_ok = (hi >= twm_pkg::CH_ZERO) && (hi <= twm_pkg::CH_NINE)
                 && (lo >= twm_pkg::CH_ZERO) && (lo <= twm_pkg::CH_NINE);
        oper = AXW'({hi[3:0], 3'b000}) + AXW'({hi[3:0], 1'b0}) + AXW'(lo[3:0]);
        oper_ok = digits_ok && (oper < AXW'(MEM_WORDS));
        pd_ok = ({1'b0, oper} + (AXW + 1)'(BLOCK_WORDS)) <= (AXW + 1)'(MEM_WORDS);
        if (op0 == twm_pkg::CH_G && op1 == twm_pkg::CH_D)
            op = twm_pkg::OP_GD;
        else if (op0 == twm_pkg::CH_P && op1 == twm_pkg::CH_D)
            op = twm_pkg::OP_PD;
        else if (op0 == twm_pkg::CH_H)
            op = twm_pkg::OP_H;
        else if (op0 == twm_pkg::CH_L && op1 == twm_pkg::CH_R)
            op = twm_pkg::OP_LR;
        else if (op0 == twm_pkg::CH_S && op1 == twm_pkg::CH_R)
            op = twm_pkg::OP_SR;
        else if (op0 == twm_pkg::CH_C && op1 == twm_pkg::CH_R)
            op = twm_pkg::OP_CR;
        else if (op0 == twm_pkg::CH_B && op1 == twm_pkg::CH_T)
            op = twm_pkg::OP_BT;
        else
            op = twm_pkg::OP_NONE;
    end

    // Select the PD byte under the walker, byte 0 at the top
    always_comb
    begin
        case (pd_idx_reg)
            2'd0:    pd_char = mem_q_reg[31:24];
            2'd1:    pd_char = mem_q_reg[23:16];
            2'd2:    pd_char = mem_q_reg[15:8];
            default: pd_char = mem_q_reg[7:0];
        endcase
        pd_skip = (pd_char == twm_pkg::CH_USCORE);
        pd_done = (pd_idx_reg == 2'd3) && (pd_left_reg == BW'(1));
    end

    assign out_free = !out_valid_reg || rsp_ready;

    // Status back to the controller
    always_comb
    begin
        sts.cmd          = item_reg.cmd;
        sts.load_ok      = item_reg.load_address < AXW'(MEM_WORDS);
        sts.mode         = mode_reg;
        sts.counter_ok   = counter_reg < AXW'(MEM_WORDS);
        sts.op           = op;
        sts.oper_ok      = oper_ok;
        sts.pd_ok        = pd_ok;
        sts.toggle       = toggle_reg;
        sts.started      = started_reg;
        sts.is_space     = item_reg.data_char == twm_pkg::CH_SPACE;
        sts.is_newline   = item_reg.data_char == twm_pkg::CH_NL;
        sts.fill_ok      = fill_reg < FILL_W'(4 * MEM_WORDS);
        sts.push_blocked = pend_valid_reg && !out_free;
        sts.out_free     = out_free;
        sts.pd_skip      = pd_skip;
        sts.pd_done      = pd_done;
    end

    // Memory write port: load, SR store, or one GD byte
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = AW'(item_reg.load_address);
        mem_wdata = item_reg.load_word;
        mem_be    = 4'b1111;
        if (cmd.mem_load)
        begin
            mem_we = 1'b1;
        end
        else if (cmd.do_sr)
        begin
            mem_we    = 1'b1;
            mem_waddr = AW'(oper);
            mem_wdata = gen_reg;
        end
        else if (cmd.data_store)
        begin
            mem_we    = 1'b1;
            mem_waddr = AW'(fill_reg >> 2);
            mem_wdata = {4{item_reg.data_char}};
            mem_be    = 4'b1000 >> fill_reg[1:0];
        end
    end

    // Memory read port: fetch, operand, or PD word
    always_comb
    begin
        mem_re    = 1'b0;
        mem_raddr = AW'(counter_reg);
        if (cmd.fetch)
        begin
            mem_re = 1'b1;
        end
        else if (cmd.read_oper)
        begin
            mem_re    = 1'b1;
            mem_raddr = AW'(oper);
        end
        else if (cmd.pd_read)
        begin
            mem_re    = 1'b1;
            mem_raddr = AW'(pd_ptr_reg);
        end
        else if (cmd.pd_byte && pd_idx_reg == 2'd3 && !pd_done)
        begin
            mem_re    = 1'b1;
            mem_raddr = AW'(pd_ptr_reg + AXW'(1));
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            for (int b = 0; b < 4; b++)
            begin
                if (mem_be[b])
                    word_mem[mem_waddr][8*b +: 8] <= mem_wdata[8*b +: 8];
            end
        end
        if (mem_re)
            mem_q_reg <= word_mem[mem_raddr];
    end

    // Hold one character back so the final one can carry last
    always_comb
    begin
        push_en   = cmd.push_nl || (cmd.pd_byte && !pd_skip);
        push_char = cmd.push_nl ? twm_pkg::CH_NL : pd_char;
        emit      = 1'b0;
        emit_item.out_char      = pend_char_reg;
        emit_item.char_valid    = 1'b1;
        emit_item.last          = 1'b0;
        emit_item.status        = status_reg;
        emit_item.counter_value = counter_reg;
        if (cmd.finish)
        begin
            emit                 = 1'b1;
            emit_item.out_char   = pend_valid_reg ? pend_char_reg : 8'h00;
            emit_item.char_valid = pend_valid_reg;
            emit_item.last       = 1'b1;
        end
        else if (push_en && pend_valid_reg)
        begin
            emit = 1'b1;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.take_item)
            item_reg <= req_payload;
        if (cmd.set_status)
            status_reg <= cmd.status;
        if (cmd.start_gd)
            fill_reg <= FILL_W'({oper, 2'b00});
        else if (cmd.data_store)
            fill_reg <= fill_reg + FILL_W'(1);
        if (cmd.pd_start)
        begin
            pd_ptr_reg  <= oper;
            pd_left_reg <= BW'(BLOCK_WORDS);
            pd_idx_reg  <= 2'd0;
        end
        else if (cmd.pd_byte)
        begin
            pd_idx_reg <= pd_idx_reg + 2'd1;
            if (pd_idx_reg == 2'd3)
            begin
                pd_ptr_reg  <= pd_ptr_reg + AXW'(1);
                pd_left_reg <= pd_left_reg - BW'(1);
            end
        end
        if (push_en)
            pend_char_reg <= push_char;
        if (emit)
            out_item_reg <= emit_item;
    end

    // Machine state and handshake control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gen_reg        <= '0;
            toggle_reg     <= 1'b0;
            started_reg    <= 1'b0;
            counter_reg    <= '0;
            mode_reg       <= twm_pkg::MODE_RUN;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.do_lr)
                gen_reg <= mem_q_reg;
            if (cmd.do_cr)
                toggle_reg <= (gen_reg == mem_q_reg);
            if (cmd.pd_start)
                started_reg <= 1'b1;
            if (cmd.fetch)
                counter_reg <= counter_reg + AXW'(1);
            else if (cmd.do_bt)
                counter_reg <= oper;
            if (cmd.start_gd)
                mode_reg <= twm_pkg::MODE_AWAIT;
            else if (cmd.set_mode)
                mode_reg <= cmd.mode;
            if (cmd.finish)
                pend_valid_reg <= 1'b0;
            else if (push_en)
                pend_valid_reg <= 1'b1;
            if (emit)
                out_valid_reg <= 1'b1;
            else if (rsp_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign rsp_valid   = out_valid_reg;
    assign rsp_payload = out_item_reg;

endmodule

// ===== rtl/twm_ctrl.sv =====
// Controller: sequences each accepted item through dispatch, decode,
// memory waits, PD byte walk and the final result. Depends on twm_pkg.
module twm_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  twm_pkg::dp_status_t sts,
    output twm_pkg::dp_cmd_t    cmd
);

    twm_pkg::ctrl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= twm_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.status = twm_pkg::ST_OK;
        cmd.mode   = twm_pkg::MODE_RUN;
        req_ready  = 1'b0;

        case (state_reg)
            // Take one item
            twm_pkg::S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.take_item = 1'b1;
                    state_next    = twm_pkg::S_DISPATCH;
                end
            end

            // Act on the command of the item
            twm_pkg::S_DISPATCH:
            begin
                cmd.set_status = 1'b1;
                state_next     = twm_pkg::S_FINISH;
                case (sts.cmd)
                    twm_pkg::CMD_LOAD:
                    begin
                        if (sts.load_ok)
                            cmd.mem_load = 1'b1;
                        else
                            cmd.status = twm_pkg::ST_ADDR;
                    end
                    twm_pkg::CMD_STEP:
                    begin
                        if (sts.mode != twm_pkg::MODE_RUN)
                        begin
                            cmd.status = twm_pkg::ST_REJECT;
                        end
                        else if (!sts.counter_ok)
                        begin
                            cmd.status   = twm_pkg::ST_ADDR;
                            cmd.set_mode = 1'b1;
                            cmd.mode     = twm_pkg::MODE_FAULT;
                        end
                        else
                        begin
                            cmd.fetch  = 1'b1;
                            state_next = twm_pkg::S_DECODE;
                        end
                    end
                    twm_pkg::CMD_DATA:
                    begin
                        if (sts.mode != twm_pkg::MODE_AWAIT)
                        begin
                            cmd.status = twm_pkg::ST_REJECT;
                        end
                        else if (sts.is_space)
                        begin
                            cmd.status = twm_pkg::ST_AWAIT;
                        end
                        else if (sts.is_newline)
                        begin
                            cmd.set_mode = 1'b1;
                            cmd.mode     = twm_pkg::MODE_RUN;
                        end
                        else if (!sts.fill_ok)
                        begin
                            cmd.status   = twm_pkg::ST_ADDR;
                            cmd.set_mode = 1'b1;
                            cmd.mode     = twm_pkg::MODE_FAULT;
                        end
                        else
                        begin
                            cmd.data_store = 1'b1;
                            cmd.status     = twm_pkg::ST_AWAIT;
                        end
                    end
                    default:
                    begin
                        cmd.status = twm_pkg::ST_REJECT;
                    end
                endcase
            end

            // Execute the fetched word
            twm_pkg::S_DECODE:
            begin
                cmd.set_status = 1'b1;
                state_next     = twm_pkg::S_FINISH;
                case (sts.op)
                    twm_pkg::OP_GD:
                    begin
                        if (sts.oper_ok)
                        begin
                            cmd.start_gd = 1'b1;
                            cmd.status   = twm_pkg::ST_AWAIT;
                        end
                        else
                        begin
                            cmd.status   = twm_pkg::ST_ADDR;
                            cmd.set_mode = 1'b1;
                            cmd.mode     = twm_pkg::MODE_FAULT;
                        end
                    end
                    twm_pkg::OP_PD:
                    begin
                        if (sts.oper_ok && sts.pd_ok)
                        begin
                            cmd.pd_start = 1'b1;
                            state_next   = sts.started ? twm_pkg::S_PD_NL
                                                       : twm_pkg::S_PD_READ;
                        end
                        else
                        begin
                            cmd.status   = twm_pkg::ST_ADDR;
                            cmd.set_mode = 1'b1;
                            cmd.mode     = twm_pkg::MODE_FAULT;
                        end
                    end
                    twm_pkg::OP_H:
                    begin
                        cmd.status   = twm_pkg::ST_HALT;
                        cmd.set_mode = 1'b1;
                        cmd.mode     = twm_pkg::MODE_HALT;
                        state_next   = twm_pkg::S_H_NL1;
                    end
                    twm_pkg::OP_LR, twm_pkg::OP_CR, twm_pkg::OP_SR:
                    begin
                        if (!sts.oper_ok)
                        begin
                            cmd.status   = twm_pkg::ST_ADDR;
                            cmd.set_mode = 1'b1;
                            cmd.mode     = twm_pkg::MODE_FAULT;
                        end
                        else if (sts.op == twm_pkg::OP_SR)
                        begin
                            cmd.do_sr = 1'b1;
                        end
                        else
                        begin
                            cmd.read_oper = 1'b1;
                            state_next    = (sts.op == twm_pkg::OP_LR) ? twm_pkg::S_LR_WAIT
                                                                       : twm_pkg::S_CR_WAIT;
                        end
                    end
                    twm_pkg::OP_BT:
                    begin
                        if (sts.toggle)
                        begin
                            if (sts.oper_ok)
                            begin
                                cmd.do_bt = 1'b1;
                            end
                            else
                            begin
                                cmd.status   = twm_pkg::ST_ADDR;
                                cmd.set_mode = 1'b1;
                                cmd.mode     = twm_pkg::MODE_FAULT;
                            end
                        end
                    end
                    default:
                    begin
                        cmd.status = twm_pkg::ST_OK;
                    end
                endcase
            end

            twm_pkg::S_LR_WAIT:
            begin
                cmd.do_lr  = 1'b1;
                state_next = twm_pkg::S_FINISH;
            end

            twm_pkg::S_CR_WAIT:
            begin
                cmd.do_cr  = 1'b1;
                state_next = twm_pkg::S_FINISH;
            end

            // Open a later PD with a newline
            twm_pkg::S_PD_NL:
            begin
                if (!sts.push_blocked)
                begin
                    cmd.push_nl = 1'b1;
                    state_next  = twm_pkg::S_PD_READ;
                end
            end

            twm_pkg::S_PD_READ:
            begin
                cmd.pd_read = 1'b1;
                state_next  = twm_pkg::S_PD_BYTES;
            end

            // Walk the block one byte a cycle, hold while output is full
            twm_pkg::S_PD_BYTES:
            begin
                if (!(sts.push_blocked && !sts.pd_skip))
                begin
                    cmd.pd_byte = 1'b1;
                    if (sts.pd_done)
                        state_next = twm_pkg::S_FINISH;
                end
            end

            twm_pkg::S_H_NL1:
            begin
                if (!sts.push_blocked)
                begin
                    cmd.push_nl = 1'b1;
                    state_next  = twm_pkg::S_H_NL2;
                end
            end

            twm_pkg::S_H_NL2:
            begin
                if (!sts.push_blocked)
                begin
                    cmd.push_nl = 1'b1;
                    state_next  = twm_pkg::S_FINISH;
                end
            end

            // Send the closing result of the item
            twm_pkg::S_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = twm_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = twm_pkg::S_IDLE;
            end
        endcase
    end

endmodule
